### rtl/dfhe_pkg.sv
// Shared types and code tables for the fixed-Huffman DEFLATE encoder.
`timescale 1ns / 1ps
`default_nettype none

package dfhe_pkg;

   typedef enum logic [1:0] {
      REQ_LITERAL = 2'd0,
      REQ_MATCH   = 2'd1,
      REQ_EOB     = 2'd2,
      REQ_HEADER  = 2'd3
   } req_kind_type;

   localparam int SEG_W   = 31;
   localparam int NBITS_W = 5;
   localparam int BUF_W   = 40;
   localparam int CNT_W   = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [8:0] LIT_SPLIT   = 9'd144;
   localparam logic [8:0] LEN_MIN     = 9'd3;
   localparam logic [8:0] LEN_MAX     = 9'd258;
   localparam logic [15:0] DIST_MIN   = 16'd1;
   localparam logic [15:0] DIST_MAX   = 16'd32768;
   localparam logic [4:0] LEN_SHORT_LAST = 5'd22;
   localparam logic [4:0] LEN_LONG_FIRST = 5'd23;

   localparam logic [8:0] LEN_BASE [0:28] = '{
      9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
      9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
      9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
   };

   localparam logic [2:0] LEN_EXTRA [0:28] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd0
   };

   localparam logic [15:0] DIST_BASE [0:29] = '{
      16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
      16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385, 16'd513,
      16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097, 16'd6145,
      16'd8193, 16'd12289, 16'd16385, 16'd24577
   };

   localparam logic [3:0] DIST_EXTRA [0:29] = '{
      4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
      4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
      4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
   };

   typedef struct packed {
      logic [SEG_W-1:0]   bits;
      logic [NBITS_W-1:0] nbits;
      logic               eob;
   } seg_type;

endpackage

`default_nettype wire

### rtl/dfhe_front.sv
// Request front end: saturate, classify and assemble one bit segment per request.
`timescale 1ns / 1ps
`default_nettype none

module dfhe_front
   import dfhe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_literal_byte,
   input  wire logic [8:0]  req_match_length,
   input  wire logic [15:0] req_match_distance,
   input  wire logic        req_final_block,
   output logic             seg_valid,
   input  wire logic        seg_ready,
   output seg_type          seg
);

   typedef struct packed {
      logic [8:0]  head;
      logic [3:0]  head_n;
      logic [4:0]  lext;
      logic [2:0]  lext_n;
      logic        has_dist;
      logic [4:0]  dcode;
      logic [12:0] dext;
      logic [3:0]  dext_n;
      logic        eob;
   } cls_type;

   function automatic logic [8:0] rev_code(input logic [8:0] code, input logic [3:0] n);
      logic [8:0] r;
      for (int i = 0; i < 9; i++) begin
         r[i] = code[8-i];
      end
      return r >> (4'd9 - n);
   endfunction

   cls_type      cls_in;
   cls_type      stage_ff;
   logic         stage_valid_ff;
   logic [8:0]   len_sat;
   logic [15:0]  dist_sat;
   logic [4:0]   len_idx;
   logic [4:0]   dist_idx;
   logic [8:0]   dcode_full;
   req_kind_type kind;
   logic [SEG_W-1:0]   acc;
   logic [NBITS_W-1:0] pos;

   assign kind = req_kind_type'(req_type);

   always_comb begin
      len_sat = req_match_length;
      if (req_match_length < LEN_MIN) begin
         len_sat = LEN_MIN;
      end else if (req_match_length > LEN_MAX) begin
         len_sat = LEN_MAX;
      end
      dist_sat = req_match_distance;
      if (req_match_distance < DIST_MIN) begin
         dist_sat = DIST_MIN;
      end else if (req_match_distance > DIST_MAX) begin
         dist_sat = DIST_MAX;
      end
      len_idx = '0;
      for (int i = 1; i < 29; i++) begin
         if (len_sat >= LEN_BASE[i]) begin
            len_idx = 5'(i);
         end
      end
      dist_idx = '0;
      for (int i = 1; i < 30; i++) begin
         if (dist_sat >= DIST_BASE[i]) begin
            dist_idx = 5'(i);
         end
      end
      dcode_full = rev_code({4'b0, dist_idx}, 4'd5);

      cls_in = '0;
      unique case (kind)
         REQ_LITERAL: begin
            if ({1'b0, req_literal_byte} < LIT_SPLIT) begin
               cls_in.head   = rev_code({1'b0, 8'h30 + req_literal_byte}, 4'd8);
               cls_in.head_n = 4'd8;
            end else begin
               cls_in.head   = rev_code(9'h190 + {1'b0, req_literal_byte} - LIT_SPLIT, 4'd9);
               cls_in.head_n = 4'd9;
            end
         end
         REQ_MATCH: begin
            if (len_idx <= LEN_SHORT_LAST) begin
               cls_in.head   = rev_code({4'b0, len_idx} + 9'd1, 4'd7);
               cls_in.head_n = 4'd7;
            end else begin
               cls_in.head   = rev_code({1'b0, 8'hC0 + {3'b0, len_idx - LEN_LONG_FIRST}}, 4'd8);
               cls_in.head_n = 4'd8;
            end
            cls_in.lext     = 5'(len_sat - LEN_BASE[len_idx]);
            cls_in.lext_n   = LEN_EXTRA[len_idx];
            cls_in.has_dist = 1'b1;
            cls_in.dcode    = dcode_full[4:0];
            cls_in.dext     = 13'(dist_sat - DIST_BASE[dist_idx]);
            cls_in.dext_n   = DIST_EXTRA[dist_idx];
         end
         REQ_EOB: begin
            cls_in.head_n = 4'd7;
            cls_in.eob    = 1'b1;
         end
         REQ_HEADER: begin
            cls_in.head   = {6'b0, 2'b01, req_final_block};
            cls_in.head_n = 4'd3;
         end
         default: begin
            cls_in = '0;
         end
      endcase
   end

   assign req_ready = !stage_valid_ff || seg_ready;
   assign seg_valid = stage_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         stage_valid_ff <= 1'b1;
      end else if (seg_ready) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_ff <= cls_in;
      end
   end

   always_comb begin
      acc = {22'b0, stage_ff.head};
      pos = {1'b0, stage_ff.head_n};
      acc = acc | (SEG_W'(stage_ff.lext) << pos);
      pos = pos + {2'b0, stage_ff.lext_n};
      if (stage_ff.has_dist) begin
         acc = acc | (SEG_W'(stage_ff.dcode) << pos);
         pos = pos + 5'd5;
         acc = acc | (SEG_W'(stage_ff.dext) << pos);
         pos = pos + {1'b0, stage_ff.dext_n};
      end
      seg.bits  = acc;
      seg.nbits = pos;
      seg.eob   = stage_ff.eob;
   end

endmodule

`default_nettype wire

### rtl/dfhe_queue.sv
// Two-entry segment queue between the front end and the bit packer.
`timescale 1ns / 1ps
`default_nettype none

module dfhe_queue
   import dfhe_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  seg_type   in_seg,
   output logic      out_valid,
   input  wire logic out_ready,
   output seg_type   out_seg
);

   seg_type    mem_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign in_ready  = count_ff != 2'(QUEUE_DEPTH);
   assign out_valid = count_ff != 2'd0;
   assign out_seg   = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_seg;
      end
   end

endmodule

`default_nettype wire

### rtl/dfhe_back.sv
// Bit packer: merge segments into the bit buffer and emit bytes through an output register.
`timescale 1ns / 1ps
`default_nettype none

module dfhe_back
   import dfhe_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  seg_valid,
   output logic       seg_ready,
   input  seg_type    seg,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_byte,
   output logic       rsp_block_done
);

   logic [BUF_W-1:0] buf_ff;
   logic [BUF_W-1:0] buf_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [CNT_W-1:0] sum;
   logic             eob_ff;
   logic             eob_in;
   logic             rsp_valid_ff;
   logic [7:0]       byte_ff;
   logic             last_ff;
   logic             done_ff;
   logic             below_byte;
   logic             pop;
   logic             emit;
   logic             last_now;

   assign below_byte = cnt_ff[CNT_W-1:3] == '0;
   assign seg_ready  = below_byte;
   assign pop        = seg_valid && below_byte;
   assign emit       = !below_byte && (!rsp_valid_ff || rsp_ready);
   assign last_now   = cnt_ff < CNT_W'(16);

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      eob_in = eob_ff;
      sum    = cnt_ff + CNT_W'(seg.nbits);
      if (pop) begin
         buf_in = buf_ff | (BUF_W'(seg.bits) << cnt_ff[2:0]);
         eob_in = seg.eob;
         if (seg.eob) begin
            cnt_in = (sum + CNT_W'(7)) & ~CNT_W'(7);
         end else begin
            cnt_in = sum;
         end
      end else if (emit) begin
         buf_in = buf_ff >> 8;
         cnt_in = cnt_ff - CNT_W'(8);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         cnt_ff       <= '0;
         eob_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_ff <= buf_in;
         cnt_ff <= cnt_in;
         eob_ff <= eob_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= buf_ff[7:0];
         last_ff <= last_now;
         done_ff <= last_now && eob_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_last_byte  = last_ff;
   assign rsp_block_done = done_ff;

endmodule

`default_nettype wire

### rtl/deflate_fixed_huffman_encoder_unit.sv
// Top level of the fixed-Huffman DEFLATE encoder: front end, segment queue, bit packer.
//
//   channel  | ports                              | moves
//   ---------+------------------------------------+-------------------------------
//   request  | req_valid/req_ready + 5 fields     | one symbol or block control
//   response | rsp_valid/rsp_ready + 3 fields     | one stream byte, LSB first
//
// A request is registered in the front stage and then in the queue; the bit packer merges
// its segment into the bit buffer and emits each completed byte (0 to 4 bytes per request).
// The packer takes a new segment only once fewer than 8 bits are left in the bit buffer.
// Each byte passes through the output register before rsp_valid presents it.
// Synchronous reset empties the pipeline and clears the bit buffer.
// A stalled response backs up through the two-entry queue to req_ready.
`timescale 1ns / 1ps
`default_nettype none

module deflate_fixed_huffman_encoder_unit
   import dfhe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_literal_byte,
   input  wire logic [8:0]  req_match_length,
   input  wire logic [15:0] req_match_distance,
   input  wire logic        req_final_block,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_byte,
   output logic             rsp_block_done
);

   seg_type front_seg;
   seg_type queue_seg;
   logic    front_valid;
   logic    front_ready;
   logic    queue_valid;
   logic    queue_ready;

   dfhe_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_literal_byte   (req_literal_byte),
      .req_match_length   (req_match_length),
      .req_match_distance (req_match_distance),
      .req_final_block    (req_final_block),
      .seg_valid          (front_valid),
      .seg_ready          (front_ready),
      .seg                (front_seg)
   );

   dfhe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_seg    (front_seg),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_seg   (queue_seg)
   );

   dfhe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .seg_valid      (queue_valid),
      .seg_ready      (queue_ready),
      .seg            (queue_seg),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_byte  (rsp_last_byte),
      .rsp_block_done (rsp_block_done)
   );

endmodule

`default_nettype wire

### rtl/dfhe_checker.sv
// Port-level checker for the fixed-Huffman DEFLATE encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dfhe_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last_byte,
   input wire logic       rsp_block_done
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_last_byte) && $stable(rsp_block_done))
      else $error("response transaction changed while stalled");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_done |-> rsp_last_byte)
      else $error("block end flagged on a byte that does not close its request");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request side not ready right after reset");

   a_no_rsp_from_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !req_valid |=> !rsp_valid)
      else $error("response transaction without any request");

endmodule

bind deflate_fixed_huffman_encoder_unit dfhe_checker u_dfhe_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_last_byte  (rsp_last_byte),
   .rsp_block_done (rsp_block_done)
);

`default_nettype wire
